// File: hw/rtl/pgi_pkg.sv
`default_nettype none

package pgi_pkg;

	localparam int SMP_W       = 16;
	localparam int LVL_W       = 16;
	localparam int PROD_W      = 32;
	localparam int ACC_W       = 24;
	localparam int COMB_W      = 17;
	localparam int GAIN_SHIFT  = 8;
	localparam int DIV_STEPS   = 16;
	localparam int DIV_CNT_W   = 4;
	localparam int CFG_IDX_W   = 2;

	localparam logic [LVL_W-1:0] LEVEL_OFFSET   = 16'd32767;
	localparam logic [SMP_W-1:0] GAIN_RESET     = 16'd256;
	localparam logic [LVL_W-1:0] DIVIDER_RESET  = 16'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_VOLUME_GAIN   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_DIVIDER = 2'd1;

	typedef struct packed {
		logic capture;
		logic div_start;
		logic comb;
		logic acc;
		logic mul;
	} pgi_cmd_t;

	typedef struct packed {
		logic div_done;
	} pgi_status_t;

endpackage

`default_nettype wire

// File: hw/rtl/pgi_div.sv
`default_nettype none

module pgi_div
	import pgi_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [LVL_W-1:0] dividend,
	input  wire logic [LVL_W-1:0] divisor,
	output logic      [LVL_W-1:0] quotient,
	output logic                  done
);

	logic [LVL_W-1:0]     quo_q;
	logic [LVL_W-1:0]     rem_q;
	logic [LVL_W-1:0]     dsr_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [LVL_W:0]       trial;
	logic                 ge;
	logic [LVL_W:0]       diff;

	assign trial = {rem_q, quo_q[LVL_W-1]};
	assign ge    = (trial >= {1'b0, dsr_q});
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_STEPS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[LVL_W-2:0], ge};
			rem_q <= ge ? diff[LVL_W-1:0] : trial[LVL_W-1:0];
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

`default_nettype wire

// File: hw/rtl/pgi_dp.sv
`default_nettype none

module pgi_dp
	import pgi_pkg::*;
#(
	parameter int RATE = 8
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire pgi_cmd_t                cmd,
	output pgi_status_t                  status,
	input  wire logic signed [SMP_W-1:0] audio_sample,
	input  wire logic                    cfg_we,
	input  wire logic [CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [LVL_W-1:0]        cfg_data,
	output logic [LVL_W-1:0]             pwm_level
);

	localparam int SH       = ACC_W + $clog2(RATE);
	localparam int RECIP_W  = ACC_W + 1;
	localparam int MULP_W   = ACC_W + RECIP_W;
	localparam longint unsigned RECIP_VAL =
		((64'd1 << SH) + 64'(RATE) - 64'd1) / 64'(RATE);
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);

	logic signed [SMP_W-1:0]  gain_q;
	logic [LVL_W-1:0]         divider_q;
	logic signed [PROD_W-1:0] prod_q;
	logic [LVL_W-1:0]         prev_q;
	logic signed [COMB_W-1:0] comb_q;
	logic [ACC_W-1:0]         acc_q;
	logic [MULP_W-1:0]        rprod_q;
	logic                     neg_q;
	logic [LVL_W-1:0]         dividend;
	logic [LVL_W-1:0]         quotient;
	logic                     div_done;
	logic [ACC_W-1:0]         mag;
	logic [ACC_W-1:0]         qv;
	logic [ACC_W-1:0]         res;

	pgi_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dividend),
		.divisor  (divider_q),
		.quotient (quotient),
		.done     (div_done)
	);

	assign status.div_done = div_done;

	assign dividend = prod_q[GAIN_SHIFT +: LVL_W] + LEVEL_OFFSET;
	assign mag      = acc_q[ACC_W-1] ? (~acc_q + 1'b1) : acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q    <= GAIN_RESET;
			divider_q <= DIVIDER_RESET;
			prev_q    <= '0;
			acc_q     <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_VOLUME_GAIN:   gain_q    <= cfg_data;
					CFG_LEVEL_DIVIDER: divider_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.comb) begin
				prev_q <= quotient;
			end
			if (cmd.acc) begin
				acc_q <= acc_q + {{(ACC_W-COMB_W){comb_q[COMB_W-1]}}, comb_q};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			prod_q <= PROD_W'(audio_sample) * PROD_W'(gain_q);
		end
		if (cmd.comb) begin
			comb_q <= $signed({quotient[LVL_W-1], quotient})
				- $signed({prev_q[LVL_W-1], prev_q});
		end
		if (cmd.mul) begin
			rprod_q <= MULP_W'(mag) * MULP_W'(RECIP);
			neg_q   <= acc_q[ACC_W-1];
		end
	end

	assign qv        = ACC_W'(rprod_q >> SH);
	assign res       = neg_q ? (~qv + 1'b1) : qv;
	assign pwm_level = res[LVL_W-1:0];

endmodule

`default_nettype wire

// File: hw/rtl/pgi_ctrl.sv
`default_nettype none

module pgi_ctrl
	import pgi_pkg::*;
#(
	parameter int RATE = 8
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  wire logic         out_ready,
	output logic              last_of_run,
	output pgi_cmd_t          cmd,
	input  wire pgi_status_t  status
);

	localparam int CNT_W = (RATE > 1) ? $clog2(RATE) : 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_WAIT,
		ST_COMB,
		ST_ACC,
		ST_MUL,
		ST_OUT
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             in_ready_q;
	logic             out_valid_q;
	logic             last_q;

	always_comb begin
		cmd           = '0;
		cmd.capture   = in_valid && in_ready_q;
		cmd.div_start = (state_q == ST_START);
		cmd.comb      = (state_q == ST_COMB);
		cmd.acc       = (state_q == ST_ACC);
		cmd.mul       = (state_q == ST_MUL);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			in_ready_q  <= 1'b1;
			out_valid_q <= 1'b0;
			last_q      <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid && in_ready_q) begin
						in_ready_q <= 1'b0;
						state_q    <= ST_START;
					end
				end
				ST_START: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (status.div_done) begin
						state_q <= ST_COMB;
					end
				end
				ST_COMB: begin
					cnt_q   <= '0;
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					out_valid_q <= 1'b1;
					last_q      <= (cnt_q == CNT_W'(RATE - 1));
					state_q     <= ST_OUT;
				end
				ST_OUT: begin
					if (out_ready) begin
						out_valid_q <= 1'b0;
						if (last_q) begin
							in_ready_q <= 1'b1;
							state_q    <= ST_IDLE;
						end else begin
							cnt_q   <= cnt_q + 1'b1;
							state_q <= ST_ACC;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready    = in_ready_q;
	assign out_valid   = out_valid_q;
	assign last_of_run = last_q;

endmodule

`default_nettype wire

// File: hw/rtl/pwm_audio_gain_interpolator.sv
// Audio gain and PWM level interpolator. Each signed sample accepted on the
// input channel is scaled by volume_gain (256 is unity), offset to an unsigned
// level, divided by level_divider in a serial divider, and then ramped
// linearly from the previous level by a first-order comb/integrator that
// emits RATE PWM levels, the last one flagged by last_of_run. Each emitted
// level is integrated, scaled by the reciprocal of RATE and then presented;
// one item is worked on at a time and the next is taken once the final level
// of the run has been accepted.
// Configuration writes are expected only while the block is idle.
`default_nettype none

module pwm_audio_gain_interpolator
	import pgi_pkg::*;
#(
	parameter int RATE = 8
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic signed [SMP_W-1:0] audio_sample,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic [LVL_W-1:0]             pwm_level,
	output logic                         last_of_run,
	input  wire logic                    cfg_valid,
	output logic                         cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [LVL_W-1:0]        cfg_data
);

	pgi_cmd_t    cmd;
	pgi_status_t status;

	assign cfg_ready = 1'b1;

	pgi_ctrl #(
		.RATE (RATE)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.last_of_run (last_of_run),
		.cmd         (cmd),
		.status      (status)
	);

	pgi_dp #(
		.RATE (RATE)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.audio_sample (audio_sample),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.pwm_level    (pwm_level)
	);

endmodule

`default_nettype wire

// File: verif/pgi_level_checker.sv
`timescale 1ns / 1ps

module pgi_level_checker
	import pgi_pkg::*;
#(
	parameter int RATE = 8
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	input  wire logic                    in_ready,
	input  wire logic signed [SMP_W-1:0] audio_sample,
	input  wire logic                    out_valid,
	input  wire logic                    out_ready,
	input  wire logic [LVL_W-1:0]        pwm_level,
	input  wire logic                    last_of_run,
	input  wire logic                    cfg_valid,
	input  wire logic                    cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [LVL_W-1:0]        cfg_data,
	output int                           levels_due,
	output int                           mismatches
);

	typedef struct packed {
		logic [LVL_W-1:0] level;
		logic             is_last;
	} pwm_beat_t;

	pwm_beat_t               ramp_q[$];
	logic signed [SMP_W-1:0] gain;
	logic [LVL_W-1:0]        divider;
	logic signed [LVL_W-1:0] prev_level;
	logic [ACC_W-1:0]        ramp_acc;
	int                      due_cnt = 0;
	int                      fail_cnt = 0;

	assign levels_due = due_cnt;
	assign mismatches = fail_cnt;

	task automatic ramp_to_sample(input logic signed [SMP_W-1:0] smp);
		logic signed [PROD_W-1:0] product;
		logic [LVL_W-1:0]         offset_level;
		logic [LVL_W-1:0]         quot;
		int                       step;
		int                       acc_val;
		pwm_beat_t                beat;
		product = PROD_W'(smp) * PROD_W'(gain);
		offset_level = product[GAIN_SHIFT +: LVL_W] + LEVEL_OFFSET;
		quot = (divider == '0) ? '1 : offset_level / divider;
		step = int'($signed(quot)) - int'(prev_level);
		prev_level = quot;
		for (int k = 0; k < RATE; k++) begin
			ramp_acc = ramp_acc + step[ACC_W-1:0];
			acc_val = int'($signed(ramp_acc));
			beat.level = LVL_W'(acc_val / RATE);
			beat.is_last = (k == RATE - 1);
			ramp_q.push_back(beat);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ramp_q.delete();
			gain = GAIN_RESET;
			divider = DIVIDER_RESET;
			prev_level = '0;
			ramp_acc = '0;
		end else begin
			if (out_valid && out_ready) begin
				if (ramp_q.size() == 0) begin
					if (fail_cnt < 10)
						$display("%0t: unexpected beat, level %h last %b", $time,
							pwm_level, last_of_run);
					fail_cnt++;
				end else begin
					pwm_beat_t want;
					want = ramp_q.pop_front();
					if (pwm_level !== want.level || last_of_run !== want.is_last) begin
						if (fail_cnt < 10)
							$display("%0t: level %h last %b, expected level %h last %b",
								$time, pwm_level, last_of_run, want.level, want.is_last);
						fail_cnt++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_VOLUME_GAIN: gain = cfg_data;
					CFG_LEVEL_DIVIDER: divider = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				ramp_to_sample(audio_sample);
		end
		due_cnt = ramp_q.size();
	end

endmodule

// File: verif/pwm_audio_gain_interpolator_tb.sv
`timescale 1ns / 1ps

module pwm_audio_gain_interpolator_tb;
	import pgi_pkg::*;

	localparam int RATE = 8;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_CYCLES = 400;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

	logic                    clk;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic signed [SMP_W-1:0] audio_sample = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic [LVL_W-1:0]        pwm_level;
	logic                    last_of_run;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [CFG_IDX_W-1:0]    cfg_index = '0;
	logic [LVL_W-1:0]        cfg_data = '0;
	int                      levels_due;
	int                      mismatches;
	int                      cycles = 0;
	int                      beats_taken = 0;
	bit                      src_gaps = 1'b1;
	bit                      sink_gaps = 1'b1;

	pwm_audio_gain_interpolator #(.RATE(RATE)) uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .audio_sample(audio_sample),
		.out_valid(out_valid), .out_ready(out_ready),
		.pwm_level(pwm_level), .last_of_run(last_of_run),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	pgi_level_checker #(.RATE(RATE)) chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .audio_sample(audio_sample),
		.out_valid(out_valid), .out_ready(out_ready),
		.pwm_level(pwm_level), .last_of_run(last_of_run),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.levels_due(levels_due), .mismatches(mismatches)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// The output side takes one long hold-off while an input beat is on offer,
	// so that the block backs up and refuses further samples.
	initial begin
		int  gap;
		bit  held;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held && beats_taken >= 200 && in_valid) begin
				held = 1'b1;
				out_ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			gap = sink_gaps ? $urandom_range(12, 0) : 0;
			if (gap > 0) begin
				out_ready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready = 1'b1;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
			beats_taken++;
		end
	end

	task automatic send_sample(input logic [SMP_W-1:0] value);
		int gap;
		gap = src_gaps ? $urandom_range(12, 0) : 0;
		repeat (gap) @(negedge clk);
		in_valid = 1'b1;
		audio_sample = value;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LVL_W-1:0] value);
		int gap;
		gap = src_gaps ? $urandom_range(12, 0) : 0;
		repeat (gap) @(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic wait_idle(input int settle);
		while (levels_due != 0)
			@(negedge clk);
		repeat (settle) @(negedge clk);
	endtask

	function automatic logic [SMP_W-1:0] draw_sample();
		case ($urandom_range(9, 0))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'($urandom_range(16, 0) - 8);
			default: return 16'($urandom());
		endcase
	endfunction

	function automatic logic [LVL_W-1:0] draw_gain();
		case ($urandom_range(7, 0))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return GAIN_RESET;
			3: return 16'($urandom_range(1024, 0));
			default: return 16'($urandom());
		endcase
	endfunction

	function automatic logic [LVL_W-1:0] draw_divider();
		case ($urandom_range(9, 0))
			0: return 16'd1;
			1: return 16'hFFFF;
			2: return 16'd0;
			3, 4, 5: return 16'($urandom_range(16, 1));
			default: return 16'($urandom());
		endcase
	endfunction

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_sample(16'h7FFF);
		send_sample(16'h8000);
		send_sample(16'h0000);
		send_sample(16'hFFFF);
		send_sample(16'h0001);

		// Unity gain with a divider of one pushes levels past the signed range.
		wait_idle(4);
		write_reg(CFG_LEVEL_DIVIDER, 16'd1);
		send_sample(16'h0001);
		send_sample(16'h7FFF);
		send_sample(16'h8000);

		wait_idle(4);
		write_reg(CFG_VOLUME_GAIN, 16'h8000);
		send_sample(16'h7FFF);
		send_sample(16'h8000);

		// A zero divider saturates the quotient.
		wait_idle(4);
		write_reg(CFG_VOLUME_GAIN, 16'h7FFF);
		write_reg(CFG_LEVEL_DIVIDER, 16'd0);
		send_sample(16'h3039);
		send_sample(16'hFFFF);

		// Writes to the unused indexes must leave both registers alone.
		wait_idle(4);
		write_reg(CFG_VOLUME_GAIN, 16'h0000);
		write_reg(CFG_LEVEL_DIVIDER, 16'hFFFF);
		write_reg(CFG_SPARE_A, 16'hFFFF);
		write_reg(CFG_SPARE_B, 16'h5555);
		send_sample(16'h7FFF);
		send_sample(16'h8000);

		for (int p = 0; p < 8; p++) begin
			wait_idle(4);
			src_gaps = ($urandom_range(3, 0) != 0);
			sink_gaps = ($urandom_range(3, 0) != 0);
			write_reg(CFG_VOLUME_GAIN, draw_gain());
			write_reg(CFG_LEVEL_DIVIDER, draw_divider());
			for (int n = 0; n < 50; n++)
				send_sample(draw_sample());
		end

		wait_idle(SETTLE_CYCLES);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
